// File: rtl/ibd_pkg.sv
// ---------------------------------------------------------------------------
// ibd_pkg
// Shared types, constants and row-scan functions of the isolated block
// detector.
// ---------------------------------------------------------------------------
package ibd_pkg;

    // widest board supported, in columns
    localparam int MAX_WIDTH = 64;
    // bits needed to hold a column count up to MAX_WIDTH
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
    // configured width after reset
    localparam logic [CNT_W-1:0] WIDTH_RST = CNT_W'(MAX_WIDTH);
    // output beat width, block_found padded to a whole byte
    localparam int OUT_W     = 8;

    typedef logic [MAX_WIDTH-1:0] row_t;

    // one row beat held in the input register
    typedef struct packed {
        row_t row;
        logic last;
    } row_beat_t;

    // handshake between the scan core and the result register
    typedef struct packed {
        logic push;   // core hands over a result this cycle
        logic found;  // block_found of that result
    } res_ctl_t;

    // bit x set where column x lies inside the configured width
    function automatic row_t width_mask(input logic [CNT_W-1:0] w);
        row_t m;
        m = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            m[i] = (w > CNT_W'(i));
        end
        return m;
    endfunction

    // bit x set if columns x and x+1 are both alive
    function automatic row_t pair_live(input row_t v);
        return v & (v >> 1);
    endfunction

    // bit x set if any of columns x-1 .. x+2 is alive
    function automatic row_t span_live(input row_t v);
        return v | (v << 1) | (v >> 1) | (v >> 2);
    endfunction

    // bit x set if column x-1 or column x+2 is alive
    function automatic row_t side_live(input row_t v);
        return (v << 1) | (v >> 2);
    endfunction

    // live 2x2 square on rows top/bottom with a dead ring of twelve cells
    function automatic logic isolated_square(input row_t above, input row_t top,
                                             input row_t bottom, input row_t below);
        row_t hit;
        hit = pair_live(top) & pair_live(bottom);
        hit = hit & ~span_live(above) & ~span_live(below);
        hit = hit & ~side_live(top) & ~side_live(bottom);
        return |hit;
    endfunction

endpackage

// File: rtl/ibd_in_stage.sv
// ---------------------------------------------------------------------------
// ibd_in_stage
// Input register: takes one row beat, masks it to the board width and holds
// it until the scan core consumes it.
// ---------------------------------------------------------------------------
module ibd_in_stage
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  ibd_pkg::row_t            s_tdata,
    input  logic                     s_tlast,
    input  logic [ibd_pkg::CNT_W-1:0] board_width,
    input  logic                     pop,
    output logic                     beat_valid,
    output ibd_pkg::row_beat_t       beat
);

    logic               valid_reg;
    logic               valid_next;
    ibd_pkg::row_beat_t beat_reg;
    logic               take;

    // free when empty or emptied this cycle
    assign s_tready = !valid_reg || pop;
    assign take     = s_tvalid && s_tready;

    // occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, masked on entry
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg.row  <= s_tdata & ibd_pkg::width_mask(board_width);
            beat_reg.last <= s_tlast;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// File: rtl/ibd_core.sv
// ---------------------------------------------------------------------------
// ibd_core
// Scan core: keeps the three previous rows and the found flag, checks every
// column of the current row at once and hands a result over on the last row.
// ---------------------------------------------------------------------------
module ibd_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               beat_valid,
    input  ibd_pkg::row_beat_t beat,
    input  logic               res_free,
    output logic               pop,
    output ibd_pkg::res_ctl_t  res
);

    ibd_pkg::row_t h0_reg, h1_reg, h2_reg;
    ibd_pkg::row_t h0_next, h1_next, h2_next;
    logic          found_reg;
    logic          found_next;
    logic          hit_mid;
    logic          hit_bottom;
    logic          found_all;

    // a last row waits while the result register is full and not draining
    assign pop = beat_valid && (!beat.last || res_free);

    // square ending at the previous row, and square on the last row itself
    assign hit_mid    = ibd_pkg::isolated_square(h2_reg, h1_reg, h0_reg, beat.row);
    assign hit_bottom = beat.last &&
                        ibd_pkg::isolated_square(h1_reg, h0_reg, beat.row, '0);
    assign found_all  = found_reg || hit_mid || hit_bottom;

    // history update, cleared after each board
    always_comb
    begin
        h0_next    = h0_reg;
        h1_next    = h1_reg;
        h2_next    = h2_reg;
        found_next = found_reg;
        if (pop)
        begin
            if (beat.last)
            begin
                h0_next    = '0;
                h1_next    = '0;
                h2_next    = '0;
                found_next = 1'b0;
            end
            else
            begin
                h0_next    = beat.row;
                h1_next    = h0_reg;
                h2_next    = h1_reg;
                found_next = found_all;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h0_reg    <= '0;
            h1_reg    <= '0;
            h2_reg    <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            h0_reg    <= h0_next;
            h1_reg    <= h1_next;
            h2_reg    <= h2_next;
            found_reg <= found_next;
        end
    end

    assign res.push  = pop && beat.last;
    assign res.found = found_all;

endmodule

// File: rtl/ibd_out_stage.sv
// ---------------------------------------------------------------------------
// ibd_out_stage
// Result register: holds one block_found beat until the sink takes it.
// ---------------------------------------------------------------------------
module ibd_out_stage
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  ibd_pkg::res_ctl_t        res,
    output logic                     res_free,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [ibd_pkg::OUT_W-1:0] m_tdata
);

    logic valid_reg;
    logic valid_next;
    logic found_reg;

    // free when empty or drained this cycle
    assign res_free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res.push)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.push)
        begin
            found_reg <= res.found;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(ibd_pkg::OUT_W-1){1'b0}}, found_reg};

endmodule

// File: rtl/isolated_block_detector_unit.sv
// ---------------------------------------------------------------------------
// isolated_block_detector_unit
// Finds an isolated 2x2 block of live cells on a binary board fed row by row.
// ---------------------------------------------------------------------------
// Rows arrive top first, one beat each, masked to board_width columns; the
// beat with tlast set closes the board and makes exactly one result beat whose
// bit 0 tells whether any 2x2 live square with all twelve surrounding cells
// dead was seen (cells off the board count as dead). A row beat is taken every
// cycle while no last row waits: each row passes the input register, the
// parallel column logic against the three stored rows, and on the last row
// the result register. Only a last row can wait, and only while the previous
// result is held in the result register and not taken. After the last row
// the stored rows and the found flag are cleared for the next board.
// board_width is to be written by the user only while no board is in flight;
// the block does not enforce this, and board_width resets to 64.
module isolated_block_detector_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    // row beats
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ibd_pkg::MAX_WIDTH-1:0] s_tdata,  // [63:0] row_cells
    input  logic                      s_tlast,      // last_row
    // result beats
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ibd_pkg::OUT_W-1:0] m_tdata,      // [0] block_found, [7:1] zero
    // configuration
    input  logic                      cfg_wr_en,
    input  logic [ibd_pkg::CNT_W-1:0] cfg_wr_data   // board_width
);

    logic [ibd_pkg::CNT_W-1:0] width_reg;
    logic                      beat_valid;
    ibd_pkg::row_beat_t        beat;
    logic                      pop;
    logic                      res_free;
    ibd_pkg::res_ctl_t         res;

    // board width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= ibd_pkg::WIDTH_RST;
        end
        else if (cfg_wr_en)
        begin
            width_reg <= cfg_wr_data;
        end
    end

    ibd_in_stage u_in
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .board_width (width_reg),
        .pop         (pop),
        .beat_valid  (beat_valid),
        .beat        (beat)
    );

    ibd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .res_free   (res_free),
        .pop        (pop),
        .res        (res)
    );

    ibd_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .res_free (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/ibd_checker.sv
// ---------------------------------------------------------------------------
// ibd_checker
// Port-level checks of the isolated block detector, bound to the top level.
// ---------------------------------------------------------------------------
module ibd_checker
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      s_tlast,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ibd_pkg::OUT_W-1:0] m_tdata
);

    // a held result beat keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed while stalled");

    // m_tvalid is high past the input and result registers after a last row
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> ##1 m_tvalid)
        else $error("no result after last row");

    // a fresh result only follows a last row
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result without a last row");

    // with the result register empty the input never stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // padding bits of the result beat stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[ibd_pkg::OUT_W-1:1] == '0)
        else $error("result padding not zero");

endmodule

bind isolated_block_detector_unit ibd_checker u_ibd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/isolated_block_detector_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// isolated_block_detector_unit_tb
// Self-checking bench for the isolated 2x2 block detector.
// ---------------------------------------------------------------------------
// Boards are fed one row beat at a time. A short table of hand-made boards
// comes first: reset width, edge columns, one-row board, a block resting on
// the row below the board, and widths of 0, 1, 2 and out of range. Random
// boards follow, with sparse, dense, faint or no noise and often a planted
// 2x2 block whose ring is usually cleared. The bench keeps its own model of
// the row history, so every result beat is checked against a predicted
// verdict. The row side sends in bursts with gaps, the result side stalls on
// its own pattern and once holds off long enough to back the block up.
module isolated_block_detector_unit_tb;

    localparam int MAX_WIDTH     = ibd_pkg::MAX_WIDTH;
    localparam int CNT_W         = ibd_pkg::CNT_W;
    localparam int OUT_W         = ibd_pkg::OUT_W;

    typedef ibd_pkg::row_t row_t;

    localparam int DIR_ROWS      = 23;
    localparam int RAND_ROWS     = 1900;
    localparam int BOARD_MAX     = 24;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;

    localparam row_t ROW_TOP2 = 64'hC000_0000_0000_0000;
    localparam row_t ROW_ALL  = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum int { RDY_ALWAYS, RDY_HALF, RDY_SPARSE } rdy_mode_t;
    typedef enum int { FILL_SPARSE, FILL_DENSE, FILL_EMPTY, FILL_FAINT } fill_t;

    // one directed row beat; known marks a verdict typed in by hand
    typedef struct {
        bit               wr;
        logic [CNT_W-1:0] width;
        row_t             cells;
        bit               last;
        bit               known;
        bit               found;
    } dir_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [MAX_WIDTH-1:0] s_tdata;   // [63:0] row_cells
    logic                 s_tlast;   // last_row
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;   // [0] block_found, [7:1] zero
    logic                 cfg_wr_en;
    logic [CNT_W-1:0]     cfg_wr_data;

    // bench model of the detector
    row_t             seen_rows [3];
    bit               seen_block;
    logic [CNT_W-1:0] width_now;

    bit        verdicts_due [$];
    bit        want_found;
    int        err_count;
    int        rows_sent;
    int        boards_sent;
    int        results_seen;
    int        blocks_seen;
    int        widths_written;
    int        idle_cycles;
    int        burst_left;
    bit        dense;
    bit        hold_req;
    rdy_mode_t ready_mode;
    int        mode_left;

    dir_row_t dir_tab [DIR_ROWS] = '{
        // block in the top rows, history above stands for dead rows
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h0, 1, 1, 1},
        // one-row board
        '{0, 0, 64'h3, 1, 1, 0},
        // block in the top two columns, closed by the row below the board
        '{0, 0, 64'h0, 0, 0, 0},
        '{0, 0, ROW_TOP2, 0, 0, 0},
        '{0, 0, ROW_TOP2, 1, 1, 1},
        // diagonal neighbour on the last row
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h4, 1, 0, 0},
        // narrowest board that can hold a block
        '{1, 2, 64'h3, 0, 0, 0},
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h0, 1, 1, 1},
        // width 0 masks every row
        '{1, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h0, 1, 1, 0},
        // width 1 leaves no room for a pair
        '{1, 1, 64'h3, 0, 0, 0},
        '{0, 0, 64'h3, 0, 0, 0},
        '{0, 0, 64'h0, 1, 1, 0},
        // width beyond range acts as full width
        '{1, 127, ROW_ALL, 0, 0, 0},
        '{0, 0, 64'h0, 0, 0, 0},
        '{0, 0, ROW_TOP2, 0, 0, 0},
        '{0, 0, ROW_TOP2, 1, 1, 1}
    };

    isolated_block_detector_unit dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // 2x2 live square on rows a, b with all twelve ring cells dead
    function automatic bit block_between(input row_t up, input row_t a,
                                         input row_t b, input row_t dn);
        row_t pairs;
        row_t ring;
        pairs = a & (a >> 1) & b & (b >> 1);
        ring  = up | (up << 1) | (up >> 1) | (up >> 2)
              | dn | (dn << 1) | (dn >> 1) | (dn >> 2)
              | (a << 1) | (a >> 2) | (b << 1) | (b >> 2);
        return |(pairs & ~ring);
    endfunction

    // advance the model by one row; returns 1 when a verdict is due
    function automatic bit board_verdict(input row_t cells, input bit last,
                                         output bit found);
        int   eff;
        row_t keep;
        row_t cur;
        bit   hit;
        eff  = (width_now > CNT_W'(MAX_WIDTH)) ? MAX_WIDTH : int'(width_now);
        keep = (eff >= MAX_WIDTH) ? '1 : ((row_t'(1) << eff) - row_t'(1));
        cur  = cells & keep;
        hit  = seen_block | block_between(seen_rows[2], seen_rows[1], seen_rows[0], cur);
        if (last)
        begin
            found        = hit | block_between(seen_rows[1], seen_rows[0], cur, '0);
            seen_rows[0] = '0;
            seen_rows[1] = '0;
            seen_rows[2] = '0;
            seen_block   = 1'b0;
            return 1'b1;
        end
        found        = 1'b0;
        seen_rows[2] = seen_rows[1];
        seen_rows[1] = seen_rows[0];
        seen_rows[0] = cur;
        seen_block   = hit;
        return 1'b0;
    endfunction

    function automatic row_t rand_row();
        return {$urandom, $urandom};
    endfunction

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] want,
                                   input logic [OUT_W-1:0] got);
        $display("%0t ns: mismatch on %s: expected %h, got %h", $time, what, want, got);
        err_count++;
    endtask

    // one row beat, with a random gap when the burst runs out outside dense mode
    task automatic send_row(input row_t cells, input bit last, input bit known,
                            input bit typed);
        bit found;
        if (!dense && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cells;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        rows_sent++;
        if (board_verdict(cells, last, found))
        begin
            verdicts_due.push_back(known ? typed : found);
            boards_sent++;
        end
    endtask

    // stop sending and wait for every outstanding verdict
    task automatic settle();
        s_tvalid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_width(input logic [CNT_W-1:0] w);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        width_now = w;
        widths_written++;
    endtask

    // random board: noise, often with a planted block, ring usually cleared
    task automatic play_board(input int height);
        row_t                 brd [BOARD_MAX];
        fill_t                fill;
        logic [MAX_WIDTH+1:0] ring;
        row_t                 clear;
        int                   eff;
        int                   k;
        int                   c;
        fill = fill_t'($urandom_range(0, 3));
        for (int i = 0; i < height; i++)
        begin
            case (fill)
                FILL_SPARSE: brd[i] = rand_row() & rand_row() & rand_row();
                FILL_DENSE:  brd[i] = rand_row();
                FILL_EMPTY:  brd[i] = '0;
                default:     brd[i] = rand_row() & rand_row() & rand_row() & rand_row()
                                    & rand_row();
            endcase
        end
        if (height >= 2 && $urandom_range(0, 3) != 0)
        begin
            eff = (width_now > CNT_W'(MAX_WIDTH)) ? MAX_WIDTH : int'(width_now);
            k   = $urandom_range(0, height - 2);
            if (eff < 2 || $urandom_range(0, 4) == 0)
                c = $urandom_range(0, MAX_WIDTH - 2);
            else
                c = $urandom_range(0, eff - 2);
            // ring bit j stands for column j-1
            if ($urandom_range(0, 3) != 0)
            begin
                ring  = (MAX_WIDTH + 2)'(4'hF) << c;
                clear = ring[MAX_WIDTH:1];
                for (int r = k - 1; r <= k + 2; r++)
                begin
                    if (r >= 0 && r < height)
                        brd[r] = brd[r] & ~clear;
                end
            end
            brd[k]     = brd[k] | (row_t'(2'b11) << c);
            brd[k + 1] = brd[k + 1] | (row_t'(2'b11) << c);
        end
        for (int i = 0; i < height; i++)
            send_row(brd[i], i == height - 1, 1'b0, 1'b0);
    endtask

    // result side: stall pattern, with one long hold on request
    initial
    begin
        m_tready  = 1'b0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode = rdy_mode_t'($urandom_range(0, 2));
                    mode_left  = $urandom_range(16, 96);
                end
                mode_left--;
                case (ready_mode)
                    RDY_ALWAYS: m_tready <= 1'b1;
                    RDY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    default:    m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // check each result beat against the oldest verdict
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[0])
                blocks_seen++;
            if (verdicts_due.size() == 0)
            begin
                report_mismatch("result beat with none outstanding", 'x, m_tdata);
            end
            else
            begin
                want_found = verdicts_due.pop_front();
                if (m_tdata !== {{(OUT_W-1){1'b0}}, want_found})
                    report_mismatch("block_found", {{(OUT_W-1){1'b0}}, want_found}, m_tdata);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: no beat for %0d cycles", $time, IDLE_LIMIT);
        $display("isolated_block_detector_unit_tb: FAIL");
        $finish;
    end

    // stimulus
    initial
    begin
        logic [CNT_W-1:0] w;
        int               nboards;
        int               phase;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        hold_req       = 1'b0;
        dense          = 1'b0;
        burst_left     = 0;
        err_count      = 0;
        rows_sent      = 0;
        boards_sent    = 0;
        results_seen   = 0;
        blocks_seen    = 0;
        widths_written = 0;
        seen_rows[0]   = '0;
        seen_rows[1]   = '0;
        seen_rows[2]   = '0;
        seen_block     = 1'b0;
        width_now      = ibd_pkg::WIDTH_RST;
        rst_n          = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed boards
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].wr)
                set_width(dir_tab[i].width);
            send_row(dir_tab[i].cells, dir_tab[i].last, dir_tab[i].known, dir_tab[i].found);
        end

        // random phases of boards
        phase = 0;
        while (rows_sent < DIR_ROWS + RAND_ROWS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w = CNT_W'(MAX_WIDTH);
                4, 5, 6, 7: w = CNT_W'($urandom_range(2, MAX_WIDTH));
                8:          w = $urandom_range(0, 1) ? CNT_W'($urandom_range(0, 2))
                                                     : CNT_W'(127);
                default:    w = CNT_W'($urandom_range(MAX_WIDTH + 1, 127));
            endcase
            if ($urandom_range(0, 3) != 0)
                set_width(w);
            else
                settle();
            dense   = ($urandom_range(0, 3) == 0);
            nboards = $urandom_range(5, 25);
            // short boards against a long result hold fill the block up
            if (phase == 2)
            begin
                set_width(CNT_W'(MAX_WIDTH));
                hold_req = 1'b1;
                dense    = 1'b1;
                for (int b = 0; b < 50; b++)
                    play_board($urandom_range(1, 2));
            end
            else
            begin
                for (int b = 0; b < nboards; b++)
                    play_board(($urandom_range(0, 7) == 0) ? $urandom_range(7, BOARD_MAX)
                                                           : $urandom_range(1, 6));
            end
            phase++;
        end

        settle();
        $display("covered %0d row beats in %0d boards, %0d verdicts, %0d with a block",
                 rows_sent, boards_sent, results_seen, blocks_seen);
        $display("width written %0d times incl. 0, 1, 2, 64 and out of range; one long hold",
                 widths_written);
        if (err_count == 0)
            $display("isolated_block_detector_unit_tb: PASS");
        else
            $display("isolated_block_detector_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: isolated_block_detector_unit.f
rtl/ibd_pkg.sv
rtl/ibd_in_stage.sv
rtl/ibd_core.sv
rtl/ibd_out_stage.sv
rtl/isolated_block_detector_unit.sv
rtl/ibd_checker.sv
bench/isolated_block_detector_unit_tb.sv
